FILE: hw/rtl/incremental_prime_sieve_top_defines.svh
// assertion macros used by the sieve back end
`ifndef INCREMENTAL_PRIME_SIEVE_TOP_DEFINES_SVH
`define INCREMENTAL_PRIME_SIEVE_TOP_DEFINES_SVH

// same-cycle implication
`define IPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ips_pkg.sv
package ips_pkg;

   localparam int VAL_W         = 16;
   localparam int DEF_MAX_LIMIT = 65535;

   typedef enum logic [1:0] {
      OP_EXTEND  = 2'd0,
      OP_NEXT    = 2'd1,
      OP_LARGEST = 2'd2,
      OP_TEST    = 2'd3
   } op_type;

   // queue entry: decoded item plus the requested limit
   typedef struct packed {
      op_type             opcode;
      logic [VAL_W-1:0]   value;
      logic [VAL_W:0]     want;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROW,
      ST_FILL,
      ST_PCHK,
      ST_PRD,
      ST_DIV,
      ST_START,
      ST_CLR,
      ST_TRD,
      ST_TCHK,
      ST_SCAN,
      ST_SCHK,
      ST_LG,
      ST_LCHK,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/ips_if.sv
interface ips_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [ips_pkg::VAL_W-1:0]   value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface ips_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ips_pkg::VAL_W-1:0]   result_value;
   logic                        prime_flag;
   logic                        limit_clipped;

   modport source (output valid, output result_value, output prime_flag,
                   output limit_clipped, input ready);
   modport sink (input valid, input result_value, input prime_flag,
                 input limit_clipped, output ready);
endinterface

FILE: hw/rtl/ips_front.sv
module ips_front (
   input  logic             clock,
   input  logic             reset,
   ips_req_if.sink          req_if,
   output ips_pkg::head_type head,
   input  logic             pop
);

   ips_pkg::entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   ips_pkg::entry_type new_entry;

   assign req_if.ready = (count_ff != 2'd2);
   assign push         = req_if.valid & req_if.ready;

   // test asks for twice the number, extend for the number itself
   always_comb begin
      new_entry.opcode = ips_pkg::op_type'(req_if.opcode);
      new_entry.value  = req_if.value;
      if (ips_pkg::op_type'(req_if.opcode) == ips_pkg::OP_TEST) begin
         new_entry.want = {req_if.value, 1'b0};
      end else begin
         new_entry.want = {1'b0, req_if.value};
      end
   end

   assign head = {(count_ff != 2'd0), entry_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: hw/rtl/ips_back.sv
`include "incremental_prime_sieve_top_defines.svh"

module ips_back #(
   parameter int MAX_LIMIT = ips_pkg::DEF_MAX_LIMIT
) (
   input  logic              clock,
   input  logic              reset,
   input  ips_pkg::head_type head,
   output logic              pop,
   ips_rsp_if.source         rsp_if
);

   localparam int VW    = ips_pkg::VAL_W;
   localparam int AW    = $clog2(MAX_LIMIT + 1);
   localparam int CW    = (AW > VW + 1) ? AW : VW + 1;
   localparam int DEPTH = MAX_LIMIT + 1;
   localparam int NW    = $clog2(AW + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_LIMIT);
   localparam logic [AW-1:0] TWO_A = AW'(2);

   ips_pkg::state_type state_ff, state_in;
   ips_pkg::entry_type entry_ff, entry_in;
   logic [AW-1:0] limit_ff, limit_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] old_ff, old_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW:0]   sq_ff, sq_in;
   logic [AW:0]   j_ff, j_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] div_ff, div_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] res_ff, res_in;
   logic          flag_ff, flag_in;
   logic          clip_ff, clip_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff;
   logic          rsp_flag_ff, rsp_clip_ff;

   logic          mem [DEPTH];
   logic          rd_ff;
   logic          we, wd;
   logic [AW-1:0] wa, ra;

   logic [CW-1:0] lim_cw, val_cw, want_cw, i_cw, cur_cw, target_cw;
   logic [AW-1:0] target;
   logic          clip_c, need, grow, sq_over, j_over, test_ok, out_load;
   logic [AW:0]   shifted, start;

   assign lim_cw    = CW'(limit_ff);
   assign val_cw    = CW'(entry_ff.value);
   assign want_cw   = CW'(entry_ff.want);
   assign i_cw      = CW'(i_ff);
   assign cur_cw    = CW'(cur_ff);
   assign clip_c    = want_cw > MAX_C;
   assign target_cw = clip_c ? MAX_C : want_cw;
   assign target    = target_cw[AW-1:0];
   assign need      = (entry_ff.opcode == ips_pkg::OP_EXTEND) ||
                      ((entry_ff.opcode == ips_pkg::OP_TEST) && (val_cw > lim_cw));
   assign grow      = need && (target_cw > lim_cw);
   assign sq_over   = sq_ff > {1'b0, limit_ff};
   assign j_over    = j_ff > {1'b0, limit_ff};
   assign test_ok   = (val_cw >= CW'(2)) && (val_cw <= lim_cw);
   assign out_load  = (state_ff == ips_pkg::ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign pop       = (state_ff == ips_pkg::ST_IDLE) && head.valid;
   assign shifted   = {rem_ff, div_ff[AW-1]};
   assign start     = {1'b0, old_ff} - {1'b0, rem_ff} +
                      ((rem_ff != '0) ? {1'b0, i_ff} : '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ips_pkg::ST_IDLE:  if (head.valid) state_in = ips_pkg::ST_GROW;
         ips_pkg::ST_GROW: begin
            if (grow) begin
               state_in = ips_pkg::ST_FILL;
            end else begin
               case (entry_ff.opcode)
                  ips_pkg::OP_EXTEND:  state_in = ips_pkg::ST_DONE;
                  ips_pkg::OP_NEXT:    state_in = ips_pkg::ST_SCAN;
                  ips_pkg::OP_LARGEST: state_in = ips_pkg::ST_LG;
                  default:             state_in = ips_pkg::ST_TRD;
               endcase
            end
         end
         ips_pkg::ST_FILL:  if (k_ff == limit_ff) state_in = ips_pkg::ST_PCHK;
         ips_pkg::ST_PCHK: begin
            if (!sq_over) begin
               state_in = ips_pkg::ST_PRD;
            end else if (entry_ff.opcode == ips_pkg::OP_TEST) begin
               state_in = ips_pkg::ST_TRD;
            end else begin
               state_in = ips_pkg::ST_DONE;
            end
         end
         ips_pkg::ST_PRD:   state_in = rd_ff ? ips_pkg::ST_DIV : ips_pkg::ST_PCHK;
         ips_pkg::ST_DIV:   if (cnt_ff == NW'(1)) state_in = ips_pkg::ST_START;
         ips_pkg::ST_START: state_in = ips_pkg::ST_CLR;
         ips_pkg::ST_CLR:   if (j_over) state_in = ips_pkg::ST_PCHK;
         ips_pkg::ST_TRD:   state_in = test_ok ? ips_pkg::ST_TCHK : ips_pkg::ST_DONE;
         ips_pkg::ST_TCHK:  state_in = ips_pkg::ST_DONE;
         ips_pkg::ST_SCAN:  state_in = (cur_ff < limit_ff) ? ips_pkg::ST_SCHK : ips_pkg::ST_DONE;
         ips_pkg::ST_SCHK:  state_in = rd_ff ? ips_pkg::ST_DONE : ips_pkg::ST_SCAN;
         ips_pkg::ST_LG:    state_in = (i_ff < TWO_A) ? ips_pkg::ST_DONE : ips_pkg::ST_LCHK;
         ips_pkg::ST_LCHK:  state_in = rd_ff ? ips_pkg::ST_DONE : ips_pkg::ST_LG;
         ips_pkg::ST_DONE:  if (out_load) state_in = ips_pkg::ST_IDLE;
         default:           state_in = ips_pkg::ST_IDLE;
      endcase
   end

   // datapath and store controls
   always_comb begin
      entry_in = entry_ff;
      limit_in = limit_ff;
      cur_in   = cur_ff;
      old_in   = old_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      sq_in    = sq_ff;
      j_in     = j_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      flag_in  = flag_ff;
      clip_in  = clip_ff;
      we       = 1'b0;
      wd       = 1'b0;
      wa       = k_ff;
      ra       = i_ff;
      case (state_ff)
         ips_pkg::ST_IDLE: if (head.valid) entry_in = head.entry;
         ips_pkg::ST_GROW: begin
            clip_in = need & clip_c;
            flag_in = 1'b0;
            res_in  = lim_cw[VW-1:0];
            i_in    = TWO_A;
            sq_in   = (AW + 1)'(4);
            if (grow) begin
               old_in   = limit_ff;
               limit_in = target;
               k_in     = limit_ff + AW'(1);
            end else if (entry_ff.opcode == ips_pkg::OP_LARGEST) begin
               i_in = limit_ff;
            end
         end
         ips_pkg::ST_FILL: begin
            we   = 1'b1;
            wd   = 1'b1;
            wa   = k_ff;
            k_in = k_ff + AW'(1);
         end
         ips_pkg::ST_PCHK: begin
            ra = i_ff;
            if (sq_over) res_in = lim_cw[VW-1:0];
         end
         ips_pkg::ST_PRD: begin
            if (rd_ff) begin
               rem_in = '0;
               div_in = old_ff;
               cnt_in = NW'(AW);
            end else begin
               i_in  = i_ff + AW'(1);
               sq_in = sq_ff + {i_ff, 1'b1};
            end
         end
         ips_pkg::ST_DIV: begin
            // restoring division, one quotient bit a cycle, remainder kept
            if (shifted >= {1'b0, i_ff}) begin
               rem_in = AW'(shifted - {1'b0, i_ff});
            end else begin
               rem_in = shifted[AW-1:0];
            end
            div_in = {div_ff[AW-2:0], 1'b0};
            cnt_in = cnt_ff - NW'(1);
         end
         ips_pkg::ST_START: j_in = (start < sq_ff) ? sq_ff : start;
         ips_pkg::ST_CLR: begin
            if (j_over) begin
               i_in  = i_ff + AW'(1);
               sq_in = sq_ff + {i_ff, 1'b1};
            end else begin
               we   = 1'b1;
               wd   = 1'b0;
               wa   = j_ff[AW-1:0];
               j_in = j_ff + {1'b0, i_ff};
            end
         end
         ips_pkg::ST_TRD: begin
            ra      = val_cw[AW-1:0];
            flag_in = 1'b0;
            res_in  = entry_ff.value;
         end
         ips_pkg::ST_TCHK: flag_in = rd_ff;
         ips_pkg::ST_SCAN: begin
            ra = cur_ff + AW'(1);
            if (cur_ff < limit_ff) begin
               cur_in = cur_ff + AW'(1);
            end else begin
               res_in = '0;
            end
         end
         ips_pkg::ST_SCHK: if (rd_ff) res_in = cur_cw[VW-1:0];
         ips_pkg::ST_LG: begin
            ra = i_ff;
            if (i_ff < TWO_A) res_in = VW'(2);
         end
         ips_pkg::ST_LCHK: begin
            if (rd_ff) begin
               res_in = i_cw[VW-1:0];
            end else begin
               i_in = i_ff - AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ips_pkg::ST_IDLE;
         limit_ff     <= AW'(1);
         cur_ff       <= AW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      old_ff   <= old_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      sq_ff    <= sq_in;
      j_ff     <= j_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      flag_ff  <= flag_in;
      clip_ff  <= clip_in;
      if (out_load) begin
         rsp_value_ff <= res_ff;
         rsp_flag_ff  <= flag_ff;
         rsp_clip_ff  <= clip_ff;
      end
   end

   // mark store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.result_value  = rsp_value_ff;
   assign rsp_if.prime_flag    = rsp_flag_ff;
   assign rsp_if.limit_clipped = rsp_clip_ff;

   `IPS_ASSERT_NOW(a_limit_max, clock, reset, 1'b1, lim_cw <= MAX_C, "limit above maximum")
   `IPS_ASSERT_NOW(a_cursor_le_limit, clock, reset, 1'b1, cur_ff <= limit_ff, "cursor past limit")
   `IPS_ASSERT_NEXT(a_fill_limit_stable, clock, reset, state_ff == ips_pkg::ST_FILL,
                    $stable(limit_ff), "limit moved during fill")
   `IPS_ASSERT_NOW(a_pop_idle, clock, reset, pop, !rsp_valid_ff || state_ff == ips_pkg::ST_IDLE,
                   "pop outside idle")

endmodule

FILE: hw/rtl/incremental_prime_sieve_top.sv
// a test within the limit goes through the grow, store read and check states before done
// the back sequencer works on one item at a time
// extend: fills each new entry, then per base prime divides to find the first multiple and clears each one
// the next prime and largest scans read and check the store one entry at a time (registered store read)
// a 2-entry queue keeps taking new transfers while the back is busy, until the queue is full
// reset: synchronous, limit and cursor go to 1; the mark store is not cleared (no clearing pass)
module incremental_prime_sieve_top #(
   parameter int MAX_LIMIT = ips_pkg::DEF_MAX_LIMIT
) (
   input logic        clock,
   input logic        reset,
   ips_req_if.sink    req_if,
   ips_rsp_if.source  rsp_if
);

   // queue head handed from the front to the back
   ips_pkg::head_type head;
   logic              pop;

   // front: takes transfers, decodes and queues them
   ips_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .head   (head),
      .pop    (pop)
   );

   // back: sequencer over the mark store, output register toward rsp
   ips_back #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

FILE: sim/incremental_prime_sieve_top_tb.sv
module incremental_prime_sieve_top_tb;

   localparam int MAX_LIM   = ips_pkg::DEF_MAX_LIMIT;
   localparam int N_RANDOM  = 2000;

   // one sieve answer as the block should return it
   typedef struct packed {
      logic [ips_pkg::VAL_W-1:0] result_value;
      logic                      prime_flag;
      logic                      limit_clipped;
   } answer_type;

   // one stimulus row; typed answer checked only when known is set
   typedef struct {
      ips_pkg::op_type           opcode;
      logic [ips_pkg::VAL_W-1:0] value;
      bit                        known;
      answer_type                ans;
   } row_type;

   logic clock = 0;
   logic reset = 1;

   ips_req_if req_ch ();
   ips_rsp_if rsp_ch ();

   incremental_prime_sieve_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #2 clock = ~clock;

   // shadow sieve state
   bit         marks [0:MAX_LIM];
   int         shadow_limit;
   int         shadow_cursor;
   answer_type pending_answers [$];
   int         mismatches = 0;
   bit         idle_on    = 1;
   int         rsp_stall  = 0;

   // sieve directed table: limit starts at 1, cursor at 1
   row_type early_rows [] = '{
      '{ips_pkg::OP_LARGEST, 16'd0,     1, '{16'd2, 1'b0, 1'b0}},  // no prime yet
      '{ips_pkg::OP_NEXT,    16'd0,     1, '{16'd0, 1'b0, 1'b0}},  // cursor at limit
      '{ips_pkg::OP_TEST,    16'd0,     1, '{16'd0, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd1,     1, '{16'd1, 1'b0, 1'b0}},
      '{ips_pkg::OP_EXTEND,  16'd0,     1, '{16'd1, 1'b0, 1'b0}},  // not above limit
      '{ips_pkg::OP_EXTEND,  16'd1,     1, '{16'd1, 1'b0, 1'b0}},
      '{ips_pkg::OP_EXTEND,  16'd2,     1, '{16'd2, 1'b0, 1'b0}},
      '{ips_pkg::OP_NEXT,    16'hffff,  1, '{16'd2, 1'b0, 1'b0}},
      '{ips_pkg::OP_NEXT,    16'd0,     1, '{16'd0, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd2,     1, '{16'd2, 1'b1, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd3,     1, '{16'd3, 1'b1, 1'b0}},  // grows to 6
      '{ips_pkg::OP_NEXT,    16'd0,     1, '{16'd3, 1'b0, 1'b0}},
      '{ips_pkg::OP_NEXT,    16'd0,     1, '{16'd5, 1'b0, 1'b0}},
      '{ips_pkg::OP_EXTEND,  16'd30,    1, '{16'd30, 1'b0, 1'b0}},
      '{ips_pkg::OP_LARGEST, 16'hffff,  1, '{16'd29, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd25,    1, '{16'd25, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd29,    1, '{16'd29, 1'b1, 1'b0}},
      '{ips_pkg::OP_EXTEND,  16'd20,    1, '{16'd30, 1'b0, 1'b0}},
      '{ips_pkg::OP_NEXT,    16'd0,     0, '{16'd0, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd97,    0, '{16'd0, 1'b0, 1'b0}}
   };

   // extremes at the full limit, run with no idling
   row_type tail_rows [] = '{
      '{ips_pkg::OP_TEST,    16'd40000, 0, '{16'd0, 1'b0, 1'b0}},
      '{ips_pkg::OP_EXTEND,  16'hffff,  1, '{16'hffff, 1'b0, 1'b0}},
      '{ips_pkg::OP_EXTEND,  16'd0,     1, '{16'hffff, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'hffff,  1, '{16'hffff, 1'b0, 1'b0}},
      '{ips_pkg::OP_LARGEST, 16'd0,     1, '{16'd65521, 1'b0, 1'b0}},
      '{ips_pkg::OP_TEST,    16'd65521, 1, '{16'd65521, 1'b1, 1'b0}},
      '{ips_pkg::OP_NEXT,    16'd0,     0, '{16'd0, 1'b0, 1'b0}}
   };

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // raise the shadow limit and strike multiples of every base prime
   function automatic bit grow_sieve(input int want);
      bit clipped;
      int old_lim, first, j;
      clipped = 0;
      if (want > MAX_LIM) begin
         want = MAX_LIM;
         clipped = 1;
      end
      if (want <= shadow_limit) return clipped;
      old_lim = shadow_limit;
      for (int k = old_lim + 1; k <= want; k++) marks[k] = 1;
      shadow_limit = want;
      for (int i = 2; i * i <= want; i++) begin
         if (!marks[i]) continue;
         first = ((old_lim + i - 1) / i) * i;
         if (first < i * i) first = i * i;
         for (j = first; j <= want; j += i) marks[j] = 0;
      end
      return clipped;
   endfunction

   function automatic answer_type sieve_answer(input ips_pkg::op_type op, input int val);
      answer_type a;
      a = '{16'd0, 1'b0, 1'b0};
      case (op)
         ips_pkg::OP_EXTEND: begin
            a.limit_clipped = grow_sieve(val);
            a.result_value  = ips_pkg::VAL_W'(shadow_limit);
         end
         ips_pkg::OP_NEXT: begin
            while (shadow_cursor < shadow_limit) begin
               shadow_cursor++;
               if (marks[shadow_cursor]) begin
                  a.result_value = ips_pkg::VAL_W'(shadow_cursor);
                  break;
               end
            end
         end
         ips_pkg::OP_LARGEST: begin
            a.result_value = ips_pkg::VAL_W'(2);
            for (int i = shadow_limit; i >= 2; i--) begin
               if (marks[i]) begin
                  a.result_value = ips_pkg::VAL_W'(i);
                  break;
               end
            end
         end
         default: begin
            if (val > shadow_limit) a.limit_clipped = grow_sieve(val * 2);
            a.prime_flag   = (val >= 2 && val <= shadow_limit && marks[val]);
            a.result_value = ips_pkg::VAL_W'(val);
         end
      endcase
      return a;
   endfunction

   // one transfer on the request side, with an optional idle burst first
   task automatic send_item(input ips_pkg::op_type op, input logic [ips_pkg::VAL_W-1:0] val,
                            input bit known, input answer_type typed);
      answer_type a;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
      a = sieve_answer(op, int'(val));
      if (known && a != typed)
         report("table answer", 32'(a), 32'(typed));
      pending_answers.push_back(a);
   endtask

   // result side stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_stall > 0) rsp_stall--;
         else if (idle_on && $urandom_range(0, 7) == 0) rsp_stall = int'($urandom_range(1, 16));
         rsp_ch.ready <= (rsp_stall == 0);
      end
   end

   // compare every result transfer with the oldest pending answer
   always @(posedge clock) begin
      answer_type exp_a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            report("unexpected result", 32'(rsp_ch.result_value), 32'd0);
         end else begin
            exp_a = pending_answers.pop_front();
            if (rsp_ch.result_value !== exp_a.result_value)
               report("result_value", 32'(rsp_ch.result_value), 32'(exp_a.result_value));
            if (rsp_ch.prime_flag !== exp_a.prime_flag)
               report("prime_flag", 32'(rsp_ch.prime_flag), 32'(exp_a.prime_flag));
            if (rsp_ch.limit_clipped !== exp_a.limit_clipped)
               report("limit_clipped", 32'(rsp_ch.limit_clipped), 32'(exp_a.limit_clipped));
         end
      end
   end

   initial begin
      int ceiling, pick;
      ips_pkg::op_type op;
      req_ch.valid  = 1'b0;
      req_ch.opcode = ips_pkg::OP_EXTEND;
      req_ch.value  = '0;
      marks[0] = 0;
      marks[1] = 0;
      shadow_limit  = 1;
      shadow_cursor = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (early_rows[i])
         send_item(early_rows[i].opcode, early_rows[i].value, early_rows[i].known,
                   early_rows[i].ans);

      // hold off until the block has drained
      req_ch.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(posedge clock);

      // random part: value range widens as the run goes on
      for (int n = 0; n < N_RANDOM; n++) begin
         ceiling = (n < N_RANDOM / 2) ? (64 << (n * 10 / N_RANDOM)) : MAX_LIM;
         if (ceiling > MAX_LIM) ceiling = MAX_LIM;
         pick = int'($urandom_range(0, 99));
         op = (pick < 15) ? ips_pkg::OP_EXTEND : (pick < 45) ? ips_pkg::OP_NEXT :
              (pick < 60) ? ips_pkg::OP_LARGEST : ips_pkg::OP_TEST;
         if (n >= N_RANDOM - 200) idle_on = 0;
         send_item(op, ips_pkg::VAL_W'($urandom_range(0, ceiling)), 0, '{16'd0, 1'b0, 1'b0});
      end

      foreach (tail_rows[i])
         send_item(tail_rows[i].opcode, tail_rows[i].value, tail_rows[i].known,
                   tail_rows[i].ans);
      req_ch.valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // generous limit: one full sieve pass plus all scans and stalls
   initial begin
      #(4 * 6000000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
